// ----- hw/rtl/ccfr_pkg.sv -----
// Package for the CRC-checked frame receiver.
// Frame geometry, sync codes, CRC constants, the FSM type and the CRC byte step.
// No dependencies.
package ccfr_pkg;

  localparam int PAYLOAD_WORDS = 16;
  localparam int FRAME_LEN     = 4 * PAYLOAD_WORDS + 4;
  localparam int LEN_W         = $clog2(FRAME_LEN);
  localparam int WCNT_W        = $clog2(PAYLOAD_WORDS + 1);

  typedef logic [LEN_W-1:0]  off_t;
  typedef logic [LEN_W:0]    off_ext_t;
  typedef logic [WCNT_W-1:0] wcnt_t;

  localparam logic [7:0]  SYNC_A   = 8'd117;
  localparam logic [7:0]  SYNC_B   = 8'd84;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_PUT
  } state_e;

  // Reflected CRC-16, one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] d);
    logic [15:0] a;
    a = acc ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      if (a[0]) begin
        a = (a >> 1) ^ CRC_POLY;
      end else begin
        a = a >> 1;
      end
    end
    return a;
  endfunction

endpackage

// ----- hw/rtl/ccfr_if.sv -----
// Handshake interfaces for the frame receiver: byte input and payload word output.
// No dependencies; none of the ccfr_pkg items are used.
interface ccfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccfr_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_value;
  logic [3:0]  word_index;
  logic        last_word;

  modport source (output valid, output word_value, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input word_value, input word_index, input last_word,
                  output ready);
endinterface

// ----- hw/rtl/ccfr_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module ccfr_ram #(
  parameter int Depth = 68,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/crc_checked_frame_receiver.sv -----
// Top level of the CRC-checked frame receiver: sync hunt, CRC/resync scan, word emit.
// Depends on ccfr_pkg, ccfr_if.sv and ccfr_ram.
//
//   channel  dir  payload                               transaction
//   rx_i     in   rx_byte[7:0]                          valid & ready
//   word_o   out  word_value[31:0], word_index[3:0],    valid & ready
//                 last_word
//
// A byte that does not complete a frame leaves the receiver in the idle state. The completing
// byte starts a pass over the circular buffer RAM (one read per cycle, FRAME_LEN reads), then
// the CRC decision; a good frame emits each word as four reads, a wait and a put.
// Resync moves the buffer base pointer and sets the fill count; no data is copied.
// Reset clears the control state; the RAM is not cleared.
// Word emission waits while word_o is stalled; rx_i ready only in the idle state.
module crc_checked_frame_receiver (
  input  logic               clk_i,
  input  logic               rst_ni,
  ccfr_byte_if.sink          rx_i,
  ccfr_word_if.source        word_o
);

  ccfr_pkg::state_e  state_q, state_d;
  ccfr_pkg::off_t    fill_q, fill_d;
  ccfr_pkg::off_t    base_q, base_d;
  ccfr_pkg::off_t    rd_cnt_q, rd_cnt_d;
  ccfr_pkg::off_t    rd_off_q;
  logic              rd_vld_q;
  ccfr_pkg::off_t    pos_q, pos_d;
  logic              found_q, found_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        prev_q, prev_d;
  logic [1:0]        bsel_q, bsel_d;
  ccfr_pkg::wcnt_t   wcnt_q, wcnt_d;
  logic [31:0]       word_q, word_d;
  logic              out_vld_q, out_vld_d;
  logic [31:0]       out_val_q, out_val_d;
  logic [3:0]        out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;

  logic              mem_we, mem_re;
  ccfr_pkg::off_t    mem_waddr, mem_raddr;
  logic [7:0]        mem_rdata;
  ccfr_pkg::off_ext_t fill_inc;
  logic              rx_acc;

  function automatic ccfr_pkg::off_t phys(ccfr_pkg::off_t base, ccfr_pkg::off_t off);
    ccfr_pkg::off_ext_t s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= ccfr_pkg::off_ext_t'(ccfr_pkg::FRAME_LEN)) begin
      s = s - ccfr_pkg::off_ext_t'(ccfr_pkg::FRAME_LEN);
    end
    return s[ccfr_pkg::LEN_W-1:0];
  endfunction

  ccfr_ram #(
    .Depth (ccfr_pkg::FRAME_LEN),
    .Width (8)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx_i.rx_byte),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rx_i.ready        = (state_q == ccfr_pkg::ST_IDLE);
  assign rx_acc            = rx_i.valid && rx_i.ready;
  assign fill_inc          = {1'b0, fill_q} + ccfr_pkg::off_ext_t'(1);
  assign mem_waddr         = phys(base_q, fill_q);
  assign mem_raddr         = phys(base_q, rd_cnt_q);
  assign word_o.valid      = out_vld_q;
  assign word_o.word_value = out_val_q;
  assign word_o.word_index = out_idx_q;
  assign word_o.last_word  = out_last_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    base_d     = base_q;
    rd_cnt_d   = rd_cnt_q;
    pos_d      = pos_q;
    found_d    = found_q;
    crc_d      = crc_q;
    prev_d     = prev_q;
    bsel_d     = bsel_q;
    wcnt_d     = wcnt_q;
    word_d     = word_q;
    out_vld_d  = out_vld_q;
    out_val_d  = out_val_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    if (out_vld_q && word_o.ready) begin
      out_vld_d = 1'b0;
    end

    // returning read data
    if (rd_vld_q && (state_q == ccfr_pkg::ST_SCAN || state_q == ccfr_pkg::ST_CHECK)) begin
      crc_d  = ccfr_pkg::crc_byte(crc_q, mem_rdata);
      prev_d = mem_rdata;
      if (!found_q && rd_off_q >= ccfr_pkg::off_t'(3) &&
          prev_q == ccfr_pkg::SYNC_A && mem_rdata == ccfr_pkg::SYNC_B) begin
        found_d = 1'b1;
        pos_d   = rd_off_q - ccfr_pkg::off_t'(1);
      end
    end
    if (rd_vld_q && (state_q == ccfr_pkg::ST_EMIT_RD ||
                     state_q == ccfr_pkg::ST_EMIT_WAIT)) begin
      word_d = {mem_rdata, word_q[31:8]};
    end

    case (state_q)
      ccfr_pkg::ST_IDLE: begin
        if (rx_acc) begin
          if (fill_q == '0 && rx_i.rx_byte != ccfr_pkg::SYNC_A) begin
            fill_d = fill_q;
          end else if (fill_q == ccfr_pkg::off_t'(1) &&
                       rx_i.rx_byte != ccfr_pkg::SYNC_B) begin
            fill_d = '0;
          end else begin
            mem_we = 1'b1;
            fill_d = fill_inc[ccfr_pkg::LEN_W-1:0];
            if (fill_inc == ccfr_pkg::off_ext_t'(ccfr_pkg::FRAME_LEN)) begin
              fill_d   = '0;
              rd_cnt_d = '0;
              crc_d    = ccfr_pkg::CRC_INIT;
              found_d  = 1'b0;
              state_d  = ccfr_pkg::ST_SCAN;
            end
          end
        end
      end
      ccfr_pkg::ST_SCAN: begin
        mem_re   = 1'b1;
        rd_cnt_d = rd_cnt_q + ccfr_pkg::off_t'(1);
        if (rd_cnt_q == ccfr_pkg::off_t'(ccfr_pkg::FRAME_LEN - 1)) begin
          state_d = ccfr_pkg::ST_CHECK;
        end
      end
      ccfr_pkg::ST_CHECK: begin
        state_d = ccfr_pkg::ST_DECIDE;
      end
      ccfr_pkg::ST_DECIDE: begin
        state_d = ccfr_pkg::ST_IDLE;
        fill_d  = '0;
        if (crc_q == 16'h0000) begin
          rd_cnt_d = ccfr_pkg::off_t'(2);
          bsel_d   = '0;
          wcnt_d   = '0;
          state_d  = ccfr_pkg::ST_EMIT_RD;
        end else if (found_q) begin
          base_d = phys(base_q, pos_q);
          fill_d = ccfr_pkg::off_t'(ccfr_pkg::FRAME_LEN) - pos_q;
        end else if (prev_q == ccfr_pkg::SYNC_A) begin
          base_d = phys(base_q, ccfr_pkg::off_t'(ccfr_pkg::FRAME_LEN - 1));
          fill_d = ccfr_pkg::off_t'(1);
        end
      end
      ccfr_pkg::ST_EMIT_RD: begin
        mem_re   = 1'b1;
        rd_cnt_d = rd_cnt_q + ccfr_pkg::off_t'(1);
        bsel_d   = bsel_q + 2'd1;
        if (bsel_q == 2'd3) begin
          state_d = ccfr_pkg::ST_EMIT_WAIT;
        end
      end
      ccfr_pkg::ST_EMIT_WAIT: begin
        state_d = ccfr_pkg::ST_EMIT_PUT;
      end
      ccfr_pkg::ST_EMIT_PUT: begin
        if (!out_vld_q || word_o.ready) begin
          out_vld_d  = 1'b1;
          out_val_d  = word_q;
          out_idx_d  = 4'(wcnt_q);
          out_last_d = (wcnt_q == ccfr_pkg::wcnt_t'(ccfr_pkg::PAYLOAD_WORDS - 1));
          wcnt_d     = wcnt_q + ccfr_pkg::wcnt_t'(1);
          if (wcnt_q == ccfr_pkg::wcnt_t'(ccfr_pkg::PAYLOAD_WORDS - 1)) begin
            state_d = ccfr_pkg::ST_IDLE;
          end else begin
            state_d = ccfr_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ccfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ccfr_pkg::ST_IDLE;
      fill_q    <= '0;
      base_q    <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      base_q    <= base_d;
      rd_vld_q  <= mem_re;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cnt_q   <= rd_cnt_d;
    rd_off_q   <= rd_cnt_q;
    pos_q      <= pos_d;
    crc_q      <= crc_d;
    prev_q     <= prev_d;
    bsel_q     <= bsel_d;
    wcnt_q     <= wcnt_d;
    word_q     <= word_d;
    out_val_q  <= out_val_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

endmodule

// ----- dv/frame_checker.sv -----
// Checker for the CRC-checked frame receiver: predicts payload words from accepted bytes
// and compares them with every word transaction in arrival order.
// Depends on ccfr_pkg and the ccfr_byte_if / ccfr_word_if interfaces.
module frame_checker
  import ccfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ccfr_byte_if        rx_i,
  ccfr_word_if        word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          words_predicted_o,
  output int          frames_passed_o,
  output int          frames_rejected_o
);

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
  } payload_word_t;

  payload_word_t expected_words [$];
  logic [7:0]    rx_window [FRAME_LEN];
  int            rx_fill;

  task automatic predict_byte(input logic [7:0] b);
    logic [15:0]   crc;
    int            hit;
    payload_word_t w;
    if (rx_fill == 0 && b != SYNC_A) return;
    if (rx_fill == 1 && b != SYNC_B) begin
      rx_fill = 0;
      return;
    end
    rx_window[rx_fill] = b;
    rx_fill++;
    if (rx_fill < FRAME_LEN) return;

    crc = CRC_INIT;
    for (int i = 0; i < FRAME_LEN; i++) begin
      crc = crc ^ {8'h00, rx_window[i]};
      for (int j = 0; j < 8; j++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end

    if (crc == 16'h0000) begin
      for (int k = 0; k < PAYLOAD_WORDS; k++) begin
        w.value = {rx_window[4*k+5], rx_window[4*k+4], rx_window[4*k+3], rx_window[4*k+2]};
        w.index = 4'(k);
        w.last  = (k == PAYLOAD_WORDS - 1);
        expected_words.push_back(w);
      end
      rx_fill = 0;
      frames_passed_o++;
      words_predicted_o += PAYLOAD_WORDS;
      return;
    end

    // bad CRC: realign on the first later sync pair, else keep a trailing first sync byte
    frames_rejected_o++;
    hit = 0;
    for (int i = 2; i + 1 < FRAME_LEN; i++) begin
      if (hit == 0 && rx_window[i] == SYNC_A && rx_window[i+1] == SYNC_B) hit = i;
    end
    if (hit != 0) begin
      for (int i = 0; i < FRAME_LEN - hit; i++) rx_window[i] = rx_window[i+hit];
      rx_fill = FRAME_LEN - hit;
    end else if (rx_window[FRAME_LEN-1] == SYNC_A) begin
      rx_window[0] = SYNC_A;
      rx_fill = 1;
    end else begin
      rx_fill = 0;
    end
  endtask

  task automatic check_word();
    payload_word_t exp_w;
    if (expected_words.size() == 0) begin
      $error("unexpected payload word: word_value %h word_index %0d last_word %0b",
             word_i.word_value, word_i.word_index, word_i.last_word);
      fail_count_o++;
      return;
    end
    exp_w = expected_words.pop_front();
    if (word_i.word_value !== exp_w.value) begin
      $error("word_value: expected %h, got %h", exp_w.value, word_i.word_value);
      fail_count_o++;
    end
    if (word_i.word_index !== exp_w.index) begin
      $error("word_index: expected %0d, got %0d", exp_w.index, word_i.word_index);
      fail_count_o++;
    end
    if (word_i.last_word !== exp_w.last) begin
      $error("last_word: expected %0b, got %0b", exp_w.last, word_i.last_word);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words.delete();
      rx_fill           = 0;
      fail_count_o      = 0;
      pending_o         = 0;
      words_predicted_o = 0;
      frames_passed_o   = 0;
      frames_rejected_o = 0;
    end else begin
      if (word_i.valid && word_i.ready) check_word();
      if (rx_i.valid && rx_i.ready) predict_byte(rx_i.rx_byte);
      pending_o = expected_words.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the frame receiver testbench: clock, reset, byte stimulus, word-side stalls, verdict.
// Depends on ccfr_pkg, the ccfr interfaces, crc_checked_frame_receiver and frame_checker.
module testbench;
  import ccfr_pkg::*;

  typedef enum int {
    SEQ_GOOD,
    SEQ_CORRUPT,
    SEQ_RESYNC,
    SEQ_TRAIL_SYNC,
    SEQ_PARTIAL,
    SEQ_NOISE
  } seq_kind_e;

  localparam int BYTE_TARGET = 430;
  localparam int WORD_TARGET = 64;
  localparam logic [7:0] HUNT_BYTES [13] = '{
    8'h00, 8'hFF, SYNC_B, 8'd116, 8'd118, SYNC_A, 8'h00,
    SYNC_A, SYNC_A, SYNC_A, 8'hFF, SYNC_A, 8'd85
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   quiet  = 1'b0;
  int   bytes_sent = 0;

  int fail_count, pending, words_predicted, frames_passed, frames_rejected;

  logic [7:0] tx_frame [FRAME_LEN];

  ccfr_byte_if rx_if ();
  ccfr_word_if word_if ();

  crc_checked_frame_receiver DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .word_o (word_if)
  );

  frame_checker frame_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_i              (rx_if),
    .word_i            (word_if),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .words_predicted_o (words_predicted),
    .frames_passed_o   (frames_passed),
    .frames_rejected_o (frames_rejected)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    @(negedge clk_i);
    if (counted) bytes_sent++;
  endtask

  task automatic build_good_frame();
    int          style;
    int          spot;
    logic [15:0] crc;
    style = $urandom_range(0, 9);
    tx_frame[0] = SYNC_A;
    tx_frame[1] = SYNC_B;
    for (int i = 2; i < FRAME_LEN - 2; i++) begin
      tx_frame[i] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    end
    // sync pair hidden in the payload
    if ($urandom_range(0, 3) == 0) begin
      spot = $urandom_range(2, FRAME_LEN - 4);
      tx_frame[spot]   = SYNC_A;
      tx_frame[spot+1] = SYNC_B;
    end
    crc = CRC_INIT;
    for (int i = 0; i < FRAME_LEN - 2; i++) begin
      crc = crc ^ {8'h00, tx_frame[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    tx_frame[FRAME_LEN-2] = crc[7:0];
    tx_frame[FRAME_LEN-1] = crc[15:8];
  endtask

  task automatic run_sequence(input seq_kind_e kind);
    int         cut;
    int         n;
    logic [7:0] lead [FRAME_LEN];
    quiet = ($urandom_range(0, 4) == 0);
    case (kind)
      SEQ_GOOD: begin
        build_good_frame();
        for (int i = 0; i < FRAME_LEN; i++) send_byte(tx_frame[i], 1'b1);
      end
      SEQ_CORRUPT: begin
        build_good_frame();
        n = $urandom_range(2, FRAME_LEN - 1);
        tx_frame[n] = tx_frame[n] ^ (8'h01 << $urandom_range(0, 7));
        for (int i = 0; i < FRAME_LEN; i++) send_byte(tx_frame[i], 1'b1);
      end
      SEQ_RESYNC: begin
        // bad frame whose tail is the head of a good one, then the rest of the good one
        build_good_frame();
        cut = $urandom_range(2, FRAME_LEN - 2);
        lead[0] = SYNC_A;
        lead[1] = SYNC_B;
        for (int i = 2; i < FRAME_LEN; i++) begin
          lead[i] = (i < cut) ? 8'($urandom_range(0, 255)) : tx_frame[i-cut];
        end
        for (int i = 0; i < FRAME_LEN; i++) send_byte(lead[i], 1'b1);
        for (int i = FRAME_LEN - cut; i < FRAME_LEN; i++) send_byte(tx_frame[i], 1'b1);
      end
      SEQ_TRAIL_SYNC: begin
        // bad frame ending in the first sync byte, then a good frame without its first byte
        build_good_frame();
        lead[0] = SYNC_A;
        lead[1] = SYNC_B;
        for (int i = 2; i < FRAME_LEN - 1; i++) lead[i] = 8'($urandom_range(0, 255));
        lead[FRAME_LEN-1] = SYNC_A;
        for (int i = 0; i < FRAME_LEN; i++) send_byte(lead[i], 1'b1);
        for (int i = 1; i < FRAME_LEN; i++) send_byte(tx_frame[i], 1'b1);
      end
      SEQ_PARTIAL: begin
        send_byte(SYNC_A, 1'b1);
        send_byte(SYNC_B, 1'b1);
        n = $urandom_range(0, 40);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endtask

  // word side: random stalls
  initial begin
    int stall;
    word_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        word_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      word_if.ready <= 1'b1;
    end
  end

  initial begin
    int r;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (HUNT_BYTES[i]) send_byte(HUNT_BYTES[i], 1'b1);
    for (int k = SEQ_GOOD; k <= SEQ_NOISE; k++) run_sequence(seq_kind_e'(k));

    while (bytes_sent < BYTE_TARGET || words_predicted < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 40)      run_sequence(SEQ_GOOD);
      else if (r < 52) run_sequence(SEQ_CORRUPT);
      else if (r < 64) run_sequence(SEQ_RESYNC);
      else if (r < 74) run_sequence(SEQ_TRAIL_SYNC);
      else if (r < 84) run_sequence(SEQ_PARTIAL);
      else             run_sequence(SEQ_NOISE);
    end
    rx_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);

    $display("Stimulus: %0d bytes into the receiver, %0d frames passed the CRC, %0d rejected.",
             bytes_sent, frames_passed, frames_rejected);
    $display("Checked %0d payload words against the prediction.", words_predicted);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout: run did not finish in time");
    $display("Test completed with failures");
    $finish;
  end

endmodule
